// ===== rtl/ils_pkg.sv =====
// ils_pkg: shared types and constants for the indexed list store
// payload structs, request codes, status codes and the per-cell control group
// no dependencies
package ils_pkg;

  localparam logic [2:0] REQ_GET       = 3'd0;
  localparam logic [2:0] REQ_APPEND    = 3'd1;
  localparam logic [2:0] REQ_PREPEND   = 3'd2;
  localparam logic [2:0] REQ_INSERT    = 3'd3;
  localparam logic [2:0] REQ_REM_FIRST = 3'd4;
  localparam logic [2:0] REQ_REM_LAST  = 3'd5;
  localparam logic [2:0] REQ_REM_AT    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } ils_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [6:0]         list_size;
    logic [1:0]         status;
  } ils_rsp_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } ils_ctrl_t;

endpackage

// ===== rtl/ils_cell.sv =====
// ils_cell: one storage cell of the list chain
// holds one element; writes, takes the lower neighbor or the upper neighbor
// depends on ils_pkg
module ils_cell #(
  parameter int POS_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                    clk,
  input  ils_pkg::ils_ctrl_t      ctrl,
  input  logic [POS_W-1:0]        pos,
  input  logic signed [31:0]      wr_data,
  input  logic signed [31:0]      prev_data,
  input  logic signed [31:0]      next_data,
  output logic signed [31:0]      data_out
);

  localparam logic [POS_W-1:0] IDX_V = CELL_IDX[POS_W-1:0];

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (IDX_V == pos) begin
        data_nxt = wr_data;
      end else if (IDX_V > pos) begin
        data_nxt = prev_data;
      end
    end else if (ctrl.rem && (IDX_V >= pos)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

// ===== rtl/indexed_list_store_unit.sv =====
// indexed_list_store_unit: ordered list of signed 32-bit values in a chain of cells
// request decode, element count, read select and result register
// depends on ils_pkg and ils_cell
//
//   channel | ports                 | direction | transaction
//   --------+-----------------------+-----------+----------------------------------
//   request | start, busy, in_req   | in        | start high and busy low at clk edge
//   result  | out_valid, out_rsp    | out       | out_valid high for one cycle
//
// one request per cycle; the result appears the cycle after acceptance
// every cell shifts up or down in the same cycle, so no request iterates
// busy stays low; the receiver cannot stall and needs no stall path
// reset (synchronous, rst_n low) empties the list and clears out_valid
module indexed_list_store_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ils_pkg::ils_req_t   in_req,
  output logic                out_valid,
  output ils_pkg::ils_rsp_t   out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ils_pkg::ils_rsp_t    out_rsp_r;
  ils_pkg::ils_rsp_t    out_rsp_nxt;

  logic                 accept;
  logic                 full;
  logic [MW-1:0]        pos_ext;
  logic [MW-1:0]        cnt_ext;
  logic [MW-1:0]        op_pos;
  ils_pkg::ils_ctrl_t   ctrl;
  logic signed [31:0]   rd_any;
  logic signed [31:0]   cell_q [CAPACITY];

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign full    = (count_r >= CAP_V);
  assign pos_ext = MW'(in_req.position);
  assign cnt_ext = MW'(count_r);

  // read select over all cells
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (pos_ext == MW'(k)) begin
        rd_any = rd_any | cell_q[k];
      end
    end
  end

  always_comb begin
    logic [MW-1:0] size_ext;
    ctrl          = '0;
    op_pos        = '0;
    count_nxt     = count_r;
    out_valid_nxt = accept;
    out_rsp_nxt   = out_rsp_r;
    out_rsp_nxt.read_value = '0;
    out_rsp_nxt.status     = ils_pkg::ST_OK;
    unique case (in_req.req_type)
      ils_pkg::REQ_GET: begin
        if (pos_ext < cnt_ext) begin
          out_rsp_nxt.read_value = rd_any;
        end else begin
          out_rsp_nxt.read_value = ils_pkg::INT_MIN;
          out_rsp_nxt.status     = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::REQ_APPEND, ils_pkg::REQ_PREPEND: begin
        if (full) begin
          out_rsp_nxt.status = ils_pkg::ST_FULL;
        end else begin
          ctrl.ins  = accept;
          op_pos    = (in_req.req_type == ils_pkg::REQ_APPEND) ? cnt_ext : '0;
          count_nxt = count_r + CW'(1);
        end
      end
      ils_pkg::REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          out_rsp_nxt.status = ils_pkg::ST_RANGE;
        end else if (full) begin
          out_rsp_nxt.status = ils_pkg::ST_FULL;
        end else begin
          ctrl.ins  = accept;
          op_pos    = pos_ext;
          count_nxt = count_r + CW'(1);
        end
      end
      ils_pkg::REQ_REM_FIRST, ils_pkg::REQ_REM_LAST: begin
        if (count_r == '0) begin
          out_rsp_nxt.status = ils_pkg::ST_RANGE;
        end else begin
          ctrl.rem  = accept && (in_req.req_type == ils_pkg::REQ_REM_FIRST);
          op_pos    = '0;
          count_nxt = count_r - CW'(1);
        end
      end
      ils_pkg::REQ_REM_AT: begin
        if (pos_ext >= cnt_ext) begin
          out_rsp_nxt.status = ils_pkg::ST_RANGE;
        end else begin
          ctrl.rem  = accept;
          op_pos    = pos_ext;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        out_rsp_nxt.status = ils_pkg::ST_RANGE;
      end
    endcase
    if (!accept) begin
      count_nxt   = count_r;
      out_rsp_nxt = out_rsp_r;
    end
    size_ext              = MW'(count_nxt);
    out_rsp_nxt.list_size = accept ? size_ext[6:0] : out_rsp_r.list_size;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [31:0] prev_d;
      logic signed [31:0] next_d;
      if (gi == 0) begin : g_first
        assign prev_d = cell_q[gi];
      end else begin : g_mid_lo
        assign prev_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_d = cell_q[gi];
      end else begin : g_mid_hi
        assign next_d = cell_q[gi+1];
      end
      ils_cell #(
        .POS_W    (MW),
        .CELL_IDX (gi)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .pos       (op_pos),
        .wr_data   (in_req.item_value),
        .prev_data (prev_d),
        .next_data (next_d),
        .data_out  (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V)
    else $error("element count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request gave no result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
               || (count_r == $past(count_r) - CW'(1)))
    else $error("element count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rsp_r.status == ils_pkg::ST_FULL)) |-> (count_r == CAP_V))
    else $error("full status with room left");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (count_r == $past(count_r)) && !out_valid_r)
    else $error("state changed without a request");

endmodule
